// ===== rtl/pidc_pkg.sv =====
// pidc_pkg: shared types and constants of the clamped pid controller
// register map, command and status bundles between controller and datapath
// no dependencies
package pidc_pkg;

  // configuration register map, byte address 4*index
  localparam int unsigned AddrW   = 5;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegGainP   = 3'd0;
  localparam logic [RegIdxW-1:0] RegGainI   = 3'd1;
  localparam logic [RegIdxW-1:0] RegGainD   = 3'd2;
  localparam logic [RegIdxW-1:0] RegDrvLo   = 3'd3;
  localparam logic [RegIdxW-1:0] RegDrvHi   = 3'd4;
  localparam logic [RegIdxW-1:0] RegAccLo   = 3'd5;
  localparam logic [RegIdxW-1:0] RegAccHi   = 3'd6;
  localparam logic [RegIdxW-1:0] RegMinStep = 3'd7;

  localparam logic [31:0] GainRst    = 32'h0000_0000;
  localparam logic [15:0] DrvLoRst   = 16'h8000;
  localparam logic [15:0] DrvHiRst   = 16'h7FFF;
  localparam logic [31:0] AccLoRst   = 32'h8000_0000;
  localparam logic [31:0] AccHiRst   = 32'h7FFF_FFFF;
  localparam logic [15:0] MinStepRst = 16'h0000;

  // transaction kinds on the input tuser
  localparam logic OpUpdate = 1'b0;
  localparam logic OpClear  = 1'b1;

  // restoring divide of a 37-bit dividend, one quotient bit a cycle
  localparam int unsigned DivSteps = 37;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
    logic [15:0] drive_floor;
    logic [15:0] drive_ceiling;
    logic [31:0] accum_floor;
    logic [31:0] accum_ceiling;
    logic [15:0] min_step;
  } cfg_t;

  typedef enum logic [1:0] {
    MulErrStep  = 2'd0,
    MulPropGain = 2'd1,
    MulIntGain  = 2'd2,
    MulDerGain  = 2'd3
  } mul_sel_e;

  typedef enum logic [1:0] {
    SumClear   = 2'd0,
    SumAddProp = 2'd1,
    SumAddHalf = 2'd2,
    SumHold    = 2'd3
  } sum_op_e;

  typedef struct packed {
    logic     take;
    logic     clear;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_upd;
    logic     div_step;
    logic     deriv_load;
    sum_op_e  sum_op;
    logic     rnd_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic deriv_go;
  } status_t;

endpackage

// ===== rtl/pidc_regs.sv =====
// pidc_regs: apb configuration registers of the clamped pid controller
// depends on pidc_pkg
module pidc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pidc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output pidc_pkg::cfg_t             cfg_o
);

  pidc_pkg::cfg_t               cfg_q;
  logic                         wr_en;
  logic [pidc_pkg::RegIdxW-1:0] idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[pidc_pkg::AddrW-1:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= pidc_pkg::GainRst;
      cfg_q.gain_i        <= pidc_pkg::GainRst;
      cfg_q.gain_d        <= pidc_pkg::GainRst;
      cfg_q.drive_floor   <= pidc_pkg::DrvLoRst;
      cfg_q.drive_ceiling <= pidc_pkg::DrvHiRst;
      cfg_q.accum_floor   <= pidc_pkg::AccLoRst;
      cfg_q.accum_ceiling <= pidc_pkg::AccHiRst;
      cfg_q.min_step      <= pidc_pkg::MinStepRst;
    end else if (wr_en) begin
      unique case (idx)
        pidc_pkg::RegGainP:   cfg_q.gain_p        <= pwdata;
        pidc_pkg::RegGainI:   cfg_q.gain_i        <= pwdata;
        pidc_pkg::RegGainD:   cfg_q.gain_d        <= pwdata;
        pidc_pkg::RegDrvLo:   cfg_q.drive_floor   <= pwdata[15:0];
        pidc_pkg::RegDrvHi:   cfg_q.drive_ceiling <= pwdata[15:0];
        pidc_pkg::RegAccLo:   cfg_q.accum_floor   <= pwdata;
        pidc_pkg::RegAccHi:   cfg_q.accum_ceiling <= pwdata;
        pidc_pkg::RegMinStep: cfg_q.min_step      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pidc_pkg::RegGainP:   prdata = cfg_q.gain_p;
      pidc_pkg::RegGainI:   prdata = cfg_q.gain_i;
      pidc_pkg::RegGainD:   prdata = cfg_q.gain_d;
      pidc_pkg::RegDrvLo:   prdata = {16'h0000, cfg_q.drive_floor};
      pidc_pkg::RegDrvHi:   prdata = {16'h0000, cfg_q.drive_ceiling};
      pidc_pkg::RegAccLo:   prdata = cfg_q.accum_floor;
      pidc_pkg::RegAccHi:   prdata = cfg_q.accum_ceiling;
      pidc_pkg::RegMinStep: prdata = {16'h0000, cfg_q.min_step};
      default:              prdata = 32'h0000_0000;
    endcase
  end

endmodule

// ===== rtl/pidc_ctrl.sv =====
// pidc_ctrl: sequencer of the clamped pid controller
// issues datapath commands, owns the divide counter and the result valid flag
// depends on pidc_pkg
module pidc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  pidc_pkg::status_t status_i,
  output pidc_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    StIdle = 10'b00_0000_0001,
    StInc  = 10'b00_0000_0010,
    StAcc  = 10'b00_0000_0100,
    StDiv  = 10'b00_0000_1000,
    StMulP = 10'b00_0001_0000,
    StMulI = 10'b00_0010_0000,
    StMulD = 10'b00_0100_0000,
    StFin  = 10'b00_1000_0000,
    StRnd  = 10'b01_0000_0000,
    StOut  = 10'b10_0000_0000
  } state_e;

  state_e                       state_q, state_d;
  logic [pidc_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         slot_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    cmd_o.mul_sel = pidc_pkg::MulErrStep;
    cmd_o.sum_op  = pidc_pkg::SumHold;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take  = 1'b1;
          cmd_o.clear = (in_op_i == pidc_pkg::OpClear);
          if (in_op_i == pidc_pkg::OpUpdate) state_d = StInc;
        end
      end
      StInc: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MulErrStep;
        state_d       = StAcc;
      end
      StAcc: begin
        cmd_o.acc_upd = 1'b1;
        div_cnt_d     = '0;
        state_d       = status_i.deriv_go ? StDiv : StMulP;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == pidc_pkg::DivCntW'(pidc_pkg::DivSteps - 1)) state_d = StMulP;
      end
      StMulP: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = pidc_pkg::MulPropGain;
        cmd_o.sum_op     = pidc_pkg::SumClear;
        cmd_o.deriv_load = 1'b1;
        state_d          = StMulI;
      end
      StMulI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MulIntGain;
        cmd_o.sum_op  = pidc_pkg::SumAddProp;
        state_d       = StMulD;
      end
      StMulD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MulDerGain;
        cmd_o.sum_op  = pidc_pkg::SumAddHalf;
        state_d       = StFin;
      end
      StFin: begin
        cmd_o.sum_op = pidc_pkg::SumAddHalf;
        state_d      = StRnd;
      end
      StRnd: begin
        cmd_o.rnd_load = 1'b1;
        state_d        = StOut;
      end
      StOut: begin
        // hold the result until the output register is free
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/pidc_dpath.sv =====
// pidc_dpath: datapath of the clamped pid controller
// shared 32x32 multiplier, integral clamp, serial divider, sum and output clamp
// depends on pidc_pkg
module pidc_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pidc_pkg::cfg_t    cfg_i,
  input  pidc_pkg::cmd_t    cmd_i,
  output pidc_pkg::status_t status_o,
  input  logic [15:0]       err_sample_i,
  input  logic [15:0]       step_time_i,
  output logic [15:0]       drive_o
);

  // item latches and controller state
  logic signed [15:0] err_q;
  logic [15:0]        dt_q;
  logic signed [31:0] accum_q;
  logic signed [15:0] last_err_q;
  logic               have_last_q;

  // multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;

  // integral update
  logic signed [33:0] inc_raw, inc, acc_sum, acc_lo, acc_hi;
  logic signed [31:0] acc_clamp;

  // divider
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [15:0]        rem_q;
  logic [36:0]        quot_q;
  logic [16:0]        rem_sh, rem_sub;
  logic               ge;
  logic               deriv_en_q, deriv_neg_q;
  logic signed [31:0] deriv_q;

  // sum and output
  logic signed [65:0] sum_q, term_p, term_h, rnd_full;
  logic signed [42:0] rnd_q, drv_lo, drv_hi;
  logic [15:0]        drive_q;

  assign status_o.deriv_go = have_last_q && (dt_q > cfg_i.min_step);
  assign drive_o           = drive_q;

  always_comb begin
    case (cmd_i.mul_sel)
      pidc_pkg::MulErrStep: begin
        mul_a = {{16{err_q[15]}}, err_q};
        mul_b = {16'h0000, dt_q};
      end
      pidc_pkg::MulPropGain: begin
        mul_a = cfg_i.gain_p;
        mul_b = {{16{err_q[15]}}, err_q};
      end
      pidc_pkg::MulIntGain: begin
        mul_a = cfg_i.gain_i;
        mul_b = accum_q;
      end
      pidc_pkg::MulDerGain: begin
        mul_a = cfg_i.gain_d;
        mul_b = deriv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // err*dt is Q.20, rounded to Q.16 half up; the product fits in 33 bits
  assign inc_raw = $signed(prod_q[33:0]) + 34'sd8;
  assign inc     = inc_raw >>> 4;
  assign acc_sum = $signed({{2{accum_q[31]}}, accum_q}) + inc;
  assign acc_lo  = $signed({{2{cfg_i.accum_floor[31]}}, cfg_i.accum_floor});
  assign acc_hi  = $signed({{2{cfg_i.accum_ceiling[31]}}, cfg_i.accum_ceiling});

  always_comb begin
    // floor wins when the limits are crossed
    if (acc_sum < acc_lo)      acc_clamp = cfg_i.accum_floor;
    else if (acc_sum > acc_hi) acc_clamp = cfg_i.accum_ceiling;
    else                       acc_clamp = acc_sum[31:0];
  end

  assign diff    = $signed({err_q[15], err_q}) - $signed({last_err_q[15], last_err_q});
  assign mag     = diff[16] ? 17'(-diff) : diff;
  assign rem_sh  = {rem_q, quot_q[36]};
  assign ge      = rem_sh >= {1'b0, dt_q};
  assign rem_sub = rem_sh - {1'b0, dt_q};

  assign term_p   = $signed({{2{prod_q[63]}}, prod_q}) <<< 7;
  assign term_h   = $signed({{3{prod_q[63]}}, prod_q[63:1]});
  assign rnd_full = sum_q + (66'sd1 <<< 22);
  assign drv_lo   = $signed({{27{cfg_i.drive_floor[15]}}, cfg_i.drive_floor});
  assign drv_hi   = $signed({{27{cfg_i.drive_ceiling[15]}}, cfg_i.drive_ceiling});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= '0;
      last_err_q  <= '0;
      have_last_q <= 1'b0;
    end else if (cmd_i.clear) begin
      accum_q     <= '0;
      last_err_q  <= '0;
      have_last_q <= 1'b0;
    end else if (cmd_i.acc_upd) begin
      accum_q     <= acc_clamp;
      last_err_q  <= err_q;
      have_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      err_q <= err_sample_i;
      dt_q  <= step_time_i;
    end
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;

    if (cmd_i.acc_upd) begin
      deriv_en_q  <= status_o.deriv_go;
      deriv_neg_q <= diff[16];
      rem_q       <= '0;
      quot_q      <= {mag, 20'h00000};
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? rem_sub[15:0] : rem_sh[15:0];
      quot_q <= {quot_q[35:0], ge};
    end

    // quotient magnitude back to a saturated signed Q16.16
    if (cmd_i.deriv_load) begin
      if (!deriv_en_q) begin
        deriv_q <= '0;
      end else if (deriv_neg_q) begin
        deriv_q <= (quot_q > 37'h00_8000_0000) ? 32'sh8000_0000 : 32'h0 - quot_q[31:0];
      end else begin
        deriv_q <= (quot_q > 37'h00_7FFF_FFFF) ? 32'sh7FFF_FFFF : quot_q[31:0];
      end
    end

    case (cmd_i.sum_op)
      pidc_pkg::SumClear:   sum_q <= '0;
      pidc_pkg::SumAddProp: sum_q <= sum_q + term_p;
      pidc_pkg::SumAddHalf: sum_q <= sum_q + term_h;
      default:              sum_q <= sum_q;
    endcase

    if (cmd_i.rnd_load) rnd_q <= rnd_full[65:23];

    // the clamp result always lies within one of the 16-bit limits
    if (cmd_i.out_load) begin
      if (rnd_q < drv_lo)      drive_q <= cfg_i.drive_floor;
      else if (rnd_q > drv_hi) drive_q <= cfg_i.drive_ceiling;
      else                     drive_q <= rnd_q[15:0];
    end
  end

endmodule

// ===== rtl/pid_controller_clamped_top.sv =====
// Fixed-point PID controller with integral clamp. An update transaction on the
// input stream (tuser 0) carries a Q8.8 error and a Q4.12 time step and yields
// one Q8.8 drive value; a clear transaction (tuser 1) empties the integral and
// the error history, leaves the block ready and yields nothing. An update steps
// through Inc, Acc, MulP, MulI, MulD, Fin, Rnd and Out before the block is ready
// again, with a bit-serial divide of the error difference by the time step
// between Acc and MulP when a derivative is formed; the four products share one
// 32x32 multiplier. A finished drive value waits in the output register while
// the next transaction is accepted. Registers sit on an APB port at 4*index and
// must be written by the user only while no update is in flight; no logic enforces it.
// depends on pidc_pkg, pidc_regs, pidc_ctrl, pidc_dpath
module pid_controller_clamped_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pidc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // err_sample[15:0], step_time[31:16]
  input  logic                       s_axis_tuser,  // op[0]: 0 update, 1 clear
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata   // drive[15:0]
);

  pidc_pkg::cfg_t    cfg;
  pidc_pkg::cmd_t    cmd;
  pidc_pkg::status_t status;

  pidc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pidc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .err_sample_i (s_axis_tdata[15:0]),
    .step_time_i  (s_axis_tdata[31:16]),
    .drive_o      (m_axis_tdata)
  );

  // an update keeps the block busy for the following cycle
  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == pidc_pkg::OpUpdate) |=> !s_axis_tready)
    else $error("input accepted right after an update transaction");

  // a clear transaction never produces a result
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == pidc_pkg::OpClear) |=> !cmd.out_load)
    else $error("clear transaction produced a result");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten before it was taken");

  // divider and multiplier are never driven in the same cycle
  a_div_mul_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.div_step && cmd.mul_en))
    else $error("divide step overlaps a multiply");

endmodule
